// File: rtl/wcc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes, types and a helper function of the windowed contact counter.
package wcc_pkg;

    localparam int NODES      = 64;
    localparam int TIME_W     = 32;
    localparam int PEER_W     = 6;
    localparam int OP_W       = 2;
    localparam int CNT_W      = 7;

    localparam int IN_DATA_W  = 104;
    localparam int IN_TIME_LSB = 0;
    localparam int IN_PEER_LSB = IN_TIME_LSB + TIME_W;
    localparam int IN_COMM_LSB = IN_PEER_LSB + PEER_W;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * CNT_W;

    localparam int DIV_STEP_W = $clog2(TIME_W);

    localparam int CNT_DIGIT  = 8;
    localparam int CNT_DIG_W  = $clog2(CNT_DIGIT + 1);
    localparam int CNT_STEPS  = (NODES + CNT_DIGIT - 1) / CNT_DIGIT;
    localparam int CNT_PAD_W  = CNT_STEPS * CNT_DIGIT;
    localparam int CNT_LEFT_W = $clog2(CNT_STEPS + 1);

    localparam logic [TIME_W-1:0] WL_RESET = 32'd21600;

    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] quot;
        logic [TIME_W-1:0] rem;
    } t_div_res;

    typedef struct packed {
        logic [CNT_W-1:0] all_cnt;
        logic [CNT_W-1:0] comm_cnt;
    } t_cnt_res;

    function automatic logic [CNT_DIG_W-1:0] popcnt_digit(input logic [CNT_DIGIT-1:0] d);
        logic [CNT_DIG_W-1:0] n;
        n = '0;
        for (int i = 0; i < CNT_DIGIT; i++) begin
            n = n + CNT_DIG_W'(d[i]);
        end
        return n;
    endfunction

endpackage

// File: rtl/wcc_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
module wcc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wcc_pkg::TIME_W-1:0] i_dividend,
    input  logic [wcc_pkg::TIME_W-1:0] i_divisor,
    output logic                      o_done,
    output wcc_pkg::t_div_res         o_res
);

    logic                              r_busy;
    logic                              r_done;
    logic [wcc_pkg::DIV_STEP_W-1:0]    r_step;
    logic [wcc_pkg::TIME_W-1:0]        r_quot;
    logic [wcc_pkg::TIME_W-1:0]        r_rem;
    logic [wcc_pkg::TIME_W-1:0]        r_den;
    logic [wcc_pkg::TIME_W:0]          w_shift;
    logic [wcc_pkg::TIME_W:0]          w_diff;
    logic                              w_ge;
    logic [wcc_pkg::TIME_W-1:0]        n_rem;

    always_comb begin
        w_shift = {r_rem, r_quot[wcc_pkg::TIME_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[wcc_pkg::TIME_W-1:0] : w_shift[wcc_pkg::TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == wcc_pkg::DIV_STEP_W'(wcc_pkg::TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[wcc_pkg::TIME_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// File: rtl/wcc_popcnt.sv
`timescale 1ns / 1ps
// Digit-serial population counter for the reported window and its community subset.
module wcc_popcnt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [wcc_pkg::NODES-1:0] i_win,
    input  logic [wcc_pkg::NODES-1:0] i_comm_win,
    output logic                     o_done,
    output wcc_pkg::t_cnt_res        o_res
);

    logic                              r_busy;
    logic                              r_done;
    logic [wcc_pkg::CNT_LEFT_W-1:0]    r_left;
    logic [wcc_pkg::CNT_PAD_W-1:0]     r_a;
    logic [wcc_pkg::CNT_PAD_W-1:0]     r_b;
    wcc_pkg::t_cnt_res                 r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= wcc_pkg::CNT_LEFT_W'(wcc_pkg::CNT_STEPS);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == wcc_pkg::CNT_LEFT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= wcc_pkg::CNT_PAD_W'(i_win);
            r_b   <= wcc_pkg::CNT_PAD_W'(i_comm_win);
            r_res <= '0;
        end else if (r_busy) begin
            r_a            <= r_a >> wcc_pkg::CNT_DIGIT;
            r_b            <= r_b >> wcc_pkg::CNT_DIGIT;
            r_res.all_cnt  <= r_res.all_cnt + wcc_pkg::CNT_W'(
                wcc_pkg::popcnt_digit(r_a[wcc_pkg::CNT_DIGIT-1:0]));
            r_res.comm_cnt <= r_res.comm_cnt + wcc_pkg::CNT_W'(
                wcc_pkg::popcnt_digit(r_b[wcc_pkg::CNT_DIGIT-1:0]));
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/windowed_contact_counter.sv
`timescale 1ns / 1ps
// Top level of the windowed contact counter: event control, window state and result register.
//
// One request is worked at a time. From acceptance until its result is loaded into the output
// register, the divider first finds the period as event_time / window_length one quotient bit
// per cycle and hands the quotient over, then the event is applied to the window state, the
// counter is loaded, it counts the reported window 8 bits at a time, and it hands the counts
// to the output register. The next request is taken in the cycle after the result is loaded,
// even while that result still waits in the output register. window_length 0 acts as 1;
// op 3 acts as a query.
// Configuration writes are always ready and must be issued only while the block is idle.
module windowed_contact_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // event_time[31:0], peer[37:32], community_mask[101:38], zero pad
    input  logic [wcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [wcc_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // global_count[6:0], local_count[13:7], zero pad
    output logic [wcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // time_backwards[0]
    output logic                          m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wcc_pkg::TIME_W-1:0]     i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_UPD  = 6'b000100,
        S_LOAD = 6'b001000,
        S_CNT  = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [wcc_pkg::TIME_W-1:0]      r_wl;
    logic [wcc_pkg::OP_W-1:0]        r_op;
    logic [wcc_pkg::PEER_W-1:0]      r_peer;
    logic [wcc_pkg::NODES-1:0]       r_comm;
    logic [wcc_pkg::NODES-1:0]       r_prev_win, n_prev_win;
    logic [wcc_pkg::NODES-1:0]       r_curr_win, n_curr_win;
    logic [wcc_pkg::NODES-1:0]       r_live, n_live;
    logic [wcc_pkg::TIME_W-1:0]      r_curr_per, n_curr_per;
    logic [wcc_pkg::TIME_W-1:0]      r_prev_per, n_prev_per;
    logic                            r_back, n_back;
    logic                            r_out_valid;
    wcc_pkg::t_cnt_res               r_out_cnt;
    logic                            r_out_back;

    logic                            w_accept;
    logic [wcc_pkg::TIME_W-1:0]      w_divisor;
    logic                            w_div_done;
    wcc_pkg::t_div_res               w_div_res;
    logic                            w_cnt_done;
    wcc_pkg::t_cnt_res               w_cnt_res;
    logic [wcc_pkg::NODES-1:0]       w_win;
    logic [wcc_pkg::NODES-1:0]       w_peer_bit;
    logic                            w_peer_ok;
    logic                            w_out_free;
    logic                            w_load_out;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_divisor  = (r_wl == '0) ? wcc_pkg::TIME_W'(1) : r_wl;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_load_out = ((r_state == S_CNT) && w_cnt_done || (r_state == S_HOLD)) && w_out_free;
    assign w_win      = (r_prev_per != r_curr_per) ? r_prev_win : r_curr_win;
    assign w_peer_bit = {{(wcc_pkg::NODES-1){1'b0}}, 1'b1} << r_peer;
    assign w_peer_ok  = {1'b0, r_peer} < (wcc_pkg::PEER_W+1)'(wcc_pkg::NODES);

    wcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (s_axis_tdata[wcc_pkg::IN_TIME_LSB +: wcc_pkg::TIME_W]),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_res      (w_div_res)
    );

    wcc_popcnt u_popcnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_win      (w_win),
        .i_comm_win (w_win & r_comm),
        .o_done     (w_cnt_done),
        .o_res      (w_cnt_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_UPD;
            end
            S_UPD:  n_state = S_LOAD;
            S_LOAD: n_state = S_CNT;
            S_CNT: begin
                if (w_cnt_done) n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_prev_win = r_prev_win;
        n_curr_win = r_curr_win;
        n_live     = r_live;
        n_curr_per = r_curr_per;
        n_prev_per = r_prev_per;
        n_back     = r_back;
        if (r_state == S_UPD) begin
            n_back = w_div_res.quot < r_curr_per;
            if (!n_back) begin
                if ({1'b0, w_div_res.quot} == ({1'b0, r_curr_per} + 1'b1)) begin
                    n_prev_win = r_curr_win;
                    n_curr_win = r_live;
                    n_prev_per = r_curr_per;
                    n_curr_per = w_div_res.quot;
                end else if (w_div_res.quot > r_curr_per) begin
                    n_prev_win = r_live;
                    n_curr_win = r_live;
                    n_prev_per = w_div_res.quot - 1'b1;
                    n_curr_per = w_div_res.quot;
                end
                if (w_peer_ok) begin
                    case (r_op)
                        wcc_pkg::OP_CONNECT: begin
                            n_live     = n_live | w_peer_bit;
                            n_curr_win = n_curr_win | w_peer_bit;
                        end
                        wcc_pkg::OP_DISCONNECT: begin
                            n_live = n_live & ~w_peer_bit;
                            if (w_div_res.rem != '0) begin
                                n_curr_win = n_curr_win | w_peer_bit;
                            end else begin
                                n_curr_win = n_curr_win & ~w_peer_bit;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= wcc_pkg::WL_RESET;
            r_prev_win  <= '0;
            r_curr_win  <= '0;
            r_live      <= '0;
            r_curr_per  <= '0;
            r_prev_per  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev_win <= n_prev_win;
            r_curr_win <= n_curr_win;
            r_live     <= n_live;
            r_curr_per <= n_curr_per;
            r_prev_per <= n_prev_per;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wl <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_back <= n_back;
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_peer <= s_axis_tdata[wcc_pkg::IN_PEER_LSB +: wcc_pkg::PEER_W];
            r_comm <= s_axis_tdata[wcc_pkg::IN_COMM_LSB +: wcc_pkg::NODES];
        end
        if (w_load_out) begin
            r_out_cnt  <= w_cnt_res;
            r_out_back <= r_back;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{wcc_pkg::OUT_PAD_W{1'b0}}, r_out_cnt.comm_cnt, r_out_cnt.all_cnt};
    assign m_axis_tuser  = r_out_back;

endmodule

// File: rtl/wcc_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the windowed contact counter and its bind to the top level.
module wcc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [wcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    logic [wcc_pkg::CNT_W-1:0] w_all;
    logic [wcc_pkg::CNT_W-1:0] w_comm;

    assign w_all  = m_axis_tdata[wcc_pkg::CNT_W-1:0];
    assign w_comm = m_axis_tdata[2*wcc_pkg::CNT_W-1:wcc_pkg::CNT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_all <= wcc_pkg::CNT_W'(wcc_pkg::NODES)))
        else $error("global count exceeds node count");

    a_local_le_global: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_comm <= w_all))
        else $error("community count exceeds global count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");

endmodule

bind windowed_contact_counter wcc_checker u_wcc_checker (.*);
